// ===== hdl/llj_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llj_pkg
// shared widths, constants and types of the least-loaded job dispatcher
// ----------------------------------------------------------------------------
package llj_pkg;

  localparam int DUR_W           = 32;
  localparam int JOB_W           = 32;
  localparam int LOAD_W          = 48;
  localparam int IDX_OUT_W       = 4;
  localparam int CNT_W           = 5;
  localparam int DEF_MAX_WORKERS = 16;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 88;

  localparam logic [CNT_W-1:0]  CNT_RESET = 5'd16;
  localparam logic [LOAD_W-1:0] LOAD_MAX  = {LOAD_W{1'b1}};
  localparam logic [JOB_W-1:0]  JOB_MAX   = {JOB_W{1'b1}};
  localparam logic [JOB_W-1:0]  JOB_FIRST = 32'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] worker_index;
    logic [JOB_W-1:0]     job_number;
    logic [LOAD_W-1:0]    new_load;
  } res_t;

  typedef struct packed {
    logic vld;
    res_t res;
  } disp_t;

endpackage

// ===== hdl/llj_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llj_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module llj_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/llj_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llj_ctrl
// per-job sequencer: scans worker loads from the load ram, keeps the running
// minimum, then writes back the saturated new load and issues the result
// ----------------------------------------------------------------------------
module llj_ctrl
  import llj_pkg::*;
#(
  parameter int MAX_WORKERS = DEF_MAX_WORKERS,
  localparam int IDX_W = $clog2(MAX_WORKERS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DUR_W-1:0]  in_dur,
  input  logic [IDX_W-1:0]  last_idx,
  input  logic              out_free,
  output disp_t             disp,
  output logic              mem_rd_en,
  output logic [IDX_W-1:0]  mem_rd_addr,
  input  logic [LOAD_W-1:0] mem_rd_data,
  output logic              mem_wr_en,
  output logic [IDX_W-1:0]  mem_wr_addr,
  output logic [LOAD_W-1:0] mem_wr_data
);

  state_t                  state_r, state_nxt;
  logic [DUR_W-1:0]        dur_r, dur_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]        best_idx_r, best_idx_nxt;
  logic [LOAD_W-1:0]       best_load_r, best_load_nxt;
  logic [JOB_W-1:0]        job_r, job_nxt;
  logic [MAX_WORKERS-1:0]  valid_r, valid_nxt;

  logic [LOAD_W-1:0]       cur_load;
  logic                    take;
  logic [IDX_W-1:0]        next_addr;
  logic [LOAD_W:0]         sum;
  logic [LOAD_W-1:0]       new_load;

  // entries never written read as zero
  assign cur_load  = rd_vld_r ? mem_rd_data : '0;
  assign take      = (rd_idx_r == '0) || (cur_load < best_load_r);
  assign next_addr = IDX_W'(rd_idx_r + 1'b1);
  assign sum       = {1'b0, best_load_r} + (LOAD_W + 1)'(dur_r);
  assign new_load  = (sum >= {1'b0, LOAD_MAX}) ? LOAD_MAX : sum[LOAD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r   <= JOB_FIRST;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dur_r       <= dur_nxt;
    rd_idx_r    <= rd_idx_nxt;
    rd_vld_r    <= rd_vld_nxt;
    best_idx_r  <= best_idx_nxt;
    best_load_r <= best_load_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    dur_nxt       = dur_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = rd_vld_r;
    best_idx_nxt  = best_idx_r;
    best_load_nxt = best_load_r;
    job_nxt       = job_r;
    valid_nxt     = valid_r;
    in_tready     = 1'b0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = best_idx_r;
    mem_wr_data   = new_load;
    disp.vld                 = 1'b0;
    disp.res.worker_index    = IDX_OUT_W'(best_idx_r);
    disp.res.job_number      = job_r;
    disp.res.new_load        = new_load;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          dur_nxt     = in_dur;
          mem_rd_en   = 1'b1;
          mem_rd_addr = '0;
          rd_idx_nxt  = '0;
          rd_vld_nxt  = valid_r[0];
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (take) begin
          best_idx_nxt  = rd_idx_r;
          best_load_nxt = cur_load;
        end
        if (rd_idx_r == last_idx) begin
          state_nxt = ST_WRITE;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = next_addr;
          rd_idx_nxt  = next_addr;
          rd_vld_nxt  = valid_r[next_addr];
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          mem_wr_en             = 1'b1;
          valid_nxt[best_idx_r] = 1'b1;
          disp.vld              = 1'b1;
          if (job_r != JOB_MAX) begin
            job_nxt = job_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/least_loaded_job_dispatcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_job_dispatcher
// greedy list scheduler: each job goes to the active worker with the least
// accumulated load, lowest index on ties
//
// in channel: one beat per job, in_tdata carries the job duration. out
// channel: one beat per job with worker index, job number and new load.
// cfg_wr_en / cfg_wr_data set the number of active workers (0 acts as 1,
// values above MAX_WORKERS act as MAX_WORKERS); write only while idle.
// the loads are read one per cycle from the load ram through one shared
// comparator, then the write state adds the duration and writes the load
// back, and the idle state takes the next job; a new job is accepted only
// after the last one has been written back.
// in_tready is high only between jobs. a finished result sits in the output
// register; the next job can be accepted and scanned while it waits, and is
// held before write-back until the output register frees up.
// reset clears all loads (per-entry valid bits), sets the job counter to 1
// and the worker count to 16.
// ----------------------------------------------------------------------------
module least_loaded_job_dispatcher
  import llj_pkg::*;
#(
  parameter int MAX_WORKERS = DEF_MAX_WORKERS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // job_duration
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // worker_index, job_number, new_load, pad
  input  logic                   cfg_wr_en,
  input  logic [CNT_W-1:0]       cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_WORKERS);

  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  last_idx;
  logic              out_valid_r;
  res_t              out_res_r;
  logic              out_free;
  disp_t             disp;
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic [LOAD_W-1:0] mem_rd_data;
  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  logic [LOAD_W-1:0] mem_wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_RESET;
    end else if (cfg_wr_en) begin
      cnt_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (cnt_r == '0) begin
      last_idx = '0;
    end else if (32'(cnt_r) > MAX_WORKERS) begin
      last_idx = IDX_W'(MAX_WORKERS - 1);
    end else begin
      last_idx = IDX_W'(cnt_r - 1'b1);
    end
  end

  assign out_free = !out_valid_r || out_tready;

  llj_ctrl #(
    .MAX_WORKERS(MAX_WORKERS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_dur     (in_tdata[DUR_W-1:0]),
    .last_idx   (last_idx),
    .out_free   (out_free),
    .disp       (disp),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data)
  );

  llj_ram #(
    .WIDTH(LOAD_W),
    .DEPTH(MAX_WORKERS)
  ) u_load_ram (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (disp.vld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (disp.vld) begin
      out_res_r <= disp.res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - LOAD_W - JOB_W - IDX_OUT_W){1'b0}},
                       out_res_r.new_load, out_res_r.job_number,
                       out_res_r.worker_index};

`ifndef ASSERT_OFF
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    disp.vld |-> (!out_valid_r || out_tready))
    else $error("result issued into a full output register");

  a_job_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    disp.vld |-> (disp.res.job_number != '0))
    else $error("job number zero");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> !mem_rd_en && !in_tready)
    else $error("load write overlaps a scan read");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the least-loaded job dispatcher: random job
// durations stream in under random source and sink gaps. A local load
// table picks the expected worker, job number and saturated load for
// each job, and these are compared field by field with the out beats.
// Several worker counts are covered (0, 31, 3, 16, random, 2, 1). A final
// run of maximum-size jobs on one worker goes with no gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import llj_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 300;
  localparam int SETTLE     = DEF_MAX_WORKERS + 4;
  localparam int FLOOD_JOBS = 40;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;   // job_duration
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;          // worker_index, job_number, new_load, pad
  logic                   cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0]       cfg_wr_data = '0;

  logic [DUR_W-1:0]  job_q[$];
  res_t              dispatch_q[$];
  logic [LOAD_W-1:0] load_mirror[DEF_MAX_WORKERS];
  logic [JOB_W-1:0]  job_mirror;
  logic [CNT_W-1:0]  worker_count_mirror;

  logic src_idle_en   = 1'b0;
  logic snk_idle_en   = 1'b0;
  logic long_hold_req = 1'b0;
  int   src_gap, snk_gap, hold_cnt, quiet_cnt;
  int   err_cnt = 0;

  least_loaded_job_dispatcher #(
    .MAX_WORKERS (DEF_MAX_WORKERS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
    err_cnt++;
  endtask

  // greedy choice over the active workers, saturating load and job counter
  task automatic dispatch_job(input logic [DUR_W-1:0] dur);
    int                n;
    int                best;
    logic [LOAD_W-1:0] ld;
    res_t              r;
    n = worker_count_mirror;
    if (n == 0) n = 1;
    if (n > DEF_MAX_WORKERS) n = DEF_MAX_WORKERS;
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (load_mirror[i] < load_mirror[best]) best = i;
    end
    ld = load_mirror[best];
    if (ld >= LOAD_MAX - LOAD_W'(dur)) ld = LOAD_MAX;
    else ld = ld + LOAD_W'(dur);
    load_mirror[best] = ld;
    r.worker_index = IDX_OUT_W'(best);
    r.job_number   = job_mirror;
    r.new_load     = ld;
    dispatch_q = {dispatch_q, r};
    if (job_mirror != JOB_MAX) job_mirror = job_mirror + 1'b1;
  endtask

  // source
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_gap   <= 0;
    end else if (in_tvalid && !in_tready) begin
      in_tvalid <= 1'b1;
    end else if (src_gap > 0) begin
      in_tvalid <= 1'b0;
      src_gap   <= src_gap - 1;
    end else if (src_idle_en && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      src_gap   <= $urandom_range(0, 16);
    end else if (job_q.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= job_q.pop_front();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // sink
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      snk_gap    <= 0;
      hold_cnt   <= 0;
    end else if (long_hold_req) begin
      out_tready <= 1'b0;
      hold_cnt   <= LONG_HOLD;
    end else if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt - 1;
    end else if (snk_gap > 0) begin
      out_tready <= 1'b0;
      snk_gap    <= snk_gap - 1;
    end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      snk_gap    <= $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin : mon
    res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) dispatch_job(in_tdata);
      if (out_tvalid && out_tready) begin
        if (dispatch_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", '0, out_tdata[63:0]);
        end else begin
          want = dispatch_q.pop_front();
          if (out_tdata[3:0] !== want.worker_index)
            report_mismatch("worker_index", want.worker_index, out_tdata[3:0]);
          if (out_tdata[35:4] !== want.job_number)
            report_mismatch("job_number", want.job_number, out_tdata[35:4]);
          if (out_tdata[83:36] !== want.new_load)
            report_mismatch("new_load", want.new_load, out_tdata[83:36]);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt == IDLE_LIMIT) begin
      $display("FAIL least_loaded_job_dispatcher");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  function automatic logic [DUR_W-1:0] random_duration();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return {DUR_W{1'b1}};
      2, 3:    return DUR_W'($urandom_range(0, 15));
      4:       return DUR_W'($urandom_range(0, 255));
      default: return DUR_W'($urandom);
    endcase
  endfunction

  task automatic add_job(input logic [DUR_W-1:0] dur);
    job_q = {job_q, dur};
  endtask

  task automatic push_jobs(input int count);
    repeat (count) add_job(random_duration());
  endtask

  task automatic wait_drained();
    while (job_q.size() != 0 || in_tvalid || dispatch_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_workers(input logic [CNT_W-1:0] value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    worker_count_mirror = value;
  endtask

  initial begin
    for (int i = 0; i < DEF_MAX_WORKERS; i++) load_mirror[i] = '0;
    job_mirror          = JOB_FIRST;
    worker_count_mirror = CNT_RESET;
    repeat (4) @(posedge clk);
    rst_n       <= 1'b1;
    src_idle_en <= 1'b1;
    snk_idle_en <= 1'b1;

    // ties on zero loads, extremes of the duration, then spread over all workers
    add_job(32'h0000_0000);
    add_job(32'h0000_0000);
    add_job(32'hFFFF_FFFF);
    add_job(32'hFFFF_FFFF);
    add_job(32'h0000_0001);
    add_job(32'h8000_0000);
    add_job(32'h5555_5555);
    add_job(32'hAAAA_AAAA);
    for (int i = 0; i < 14; i++) add_job(DUR_W'(i + 2));

    // zero acts as a single worker
    set_workers('0);
    push_jobs(25);

    // above the maximum clamps, with a long sink stall that backs up the input
    set_workers({CNT_W{1'b1}});
    push_jobs(80);
    @(posedge clk);
    long_hold_req <= 1'b1;
    @(posedge clk);
    long_hold_req <= 1'b0;

    // source pauses until everything has come back
    set_workers(CNT_W'(3));
    push_jobs(30);
    wait_drained();
    push_jobs(30);

    set_workers(CNT_W'(16));
    src_idle_en <= 1'b0;
    snk_idle_en <= 1'b0;
    push_jobs(60);
    wait_drained();
    src_idle_en <= 1'b1;
    snk_idle_en <= 1'b1;

    repeat (4) begin
      set_workers(CNT_W'($urandom_range(0, 31)));
      push_jobs($urandom_range(40, 80));
    end

    // workers leave and rejoin with their old loads
    set_workers(CNT_W'(2));
    push_jobs(40);
    set_workers(CNT_W'(16));
    push_jobs(40);

    // one worker, full-size jobs back to back
    set_workers(CNT_W'(1));
    src_idle_en <= 1'b0;
    snk_idle_en <= 1'b0;
    repeat (FLOOD_JOBS) add_job({DUR_W{1'b1}});
    add_job(32'h0000_0000);
    add_job(32'h0000_0005);
    add_job(32'h1234_5678);
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    if (err_cnt == 0) begin
      $display("PASS least_loaded_job_dispatcher");
    end else begin
      $display("FAIL least_loaded_job_dispatcher");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/llj_pkg.sv
hdl/llj_ram.sv
hdl/llj_ctrl.sv
hdl/least_loaded_job_dispatcher.sv
tb/sv/tb_top.sv
